// ----- rtl/save_type_signature_scanner_assert.svh -----
// assertion macros for the port-level checker
`ifndef SAVE_TYPE_SIGNATURE_SCANNER_ASSERT_SVH
`define SAVE_TYPE_SIGNATURE_SCANNER_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define STSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while rst is high
`define STSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/stss_pkg.sv -----
// shared types, constants and signature functions of the save type scanner
`default_nettype none

package stss_pkg;

   localparam int COUNT_BITS_DEFAULT = 25;
   localparam int WIN_DEPTH = 9;
   localparam int VIEW_LEN = 10;
   localparam int MIN_FOLLOW = 16;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_EEPROM   = 3'd1,
      KIND_SRAM     = 3'd2,
      KIND_FLASH64  = 3'd3,
      KIND_FLASH128 = 3'd4
   } save_kind_type;

   // ten-byte view, element 0 is the oldest byte
   typedef logic [VIEW_LEN-1:0][7:0] view_type;

   // signatures left-justified in 80 bits, first character in the top byte
   localparam logic [79:0] SIG_EEPROM   = {"EEPROM", "_V", 16'h0000};
   localparam logic [79:0] SIG_SRAM     = {"SRAM_V", 32'h0000_0000};
   localparam logic [79:0] SIG_SRAM_F   = {"SRAM_F", "_V", 16'h0000};
   localparam logic [79:0] SIG_FLASH    = {"FLASH_V", 24'h00_0000};
   localparam logic [79:0] SIG_FLASH512 = {"FLASH512", "_V"};
   localparam logic [79:0] SIG_FLASH1M  = {"FLASH1M", "_V", 8'h00};

   function automatic logic sig_match(view_type view, logic [79:0] sig, logic [3:0] len);
      logic hit;
      hit = 1'b1;
      for (int i = 0; i < VIEW_LEN; i++) begin
         if ((i < int'(len)) && (view[i] != sig[79-8*i -: 8])) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

   function automatic save_kind_type classify(view_type view);
      save_kind_type kind;
      priority if (sig_match(view, SIG_EEPROM, 4'd8)) begin
         kind = KIND_EEPROM;
      end else if (sig_match(view, SIG_SRAM, 4'd6) || sig_match(view, SIG_SRAM_F, 4'd8)) begin
         kind = KIND_SRAM;
      end else if (sig_match(view, SIG_FLASH, 4'd7)
                   || sig_match(view, SIG_FLASH512, 4'd10)) begin
         kind = KIND_FLASH64;
      end else if (sig_match(view, SIG_FLASH1M, 4'd9)) begin
         kind = KIND_FLASH128;
      end else begin
         kind = KIND_NONE;
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/save_type_signature_scanner.sv -----
// save type scanner: matches save signatures in a byte stream, one result per image
//
// usage
//   req channel takes one image byte per transfer in address order; req_tlast
//   marks the final byte of the image. rsp channel gives one transfer per
//   image, on its last byte, carrying the detected save kind.
//   every start position is tested against six signatures over a ten-byte
//   view; the earliest hit wins, and it counts only when at least sixteen
//   bytes of the image follow its start position.
// timing
//   one byte per cycle sustained while no result blocks the input; the
//   signature compare and the hit update fit in the single stage between the
//   input register and the result register, which drives rsp.
// reset and stall
//   reset empties both registers and clears counter and hit state. while a
//   result waits on rsp_tready, bytes keep flowing until a second last byte
//   reaches the input register; req_tready then drops until the result goes.
//   after each last byte the scanner starts a fresh image.
`default_nettype none

module save_type_signature_scanner #(
   parameter int COUNT_BITS = stss_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // last_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [2:0] save_kind, [7:3] zero
);

   localparam logic [COUNT_BITS-1:0] FIRST_TEST = COUNT_BITS'(stss_pkg::WIN_DEPTH);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS:0]   FOLLOW     = (COUNT_BITS+1)'(stss_pkg::MIN_FOLLOW);

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_data_ff, s1_data_in;
   logic                 s1_last_ff, s1_last_in;

   // scan state
   logic [7:0]           win_ff [stss_pkg::WIN_DEPTH];
   logic [7:0]           win_in [stss_pkg::WIN_DEPTH];
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                 hit_found_ff, hit_found_in;
   logic [COUNT_BITS-1:0] hit_pos_ff, hit_pos_in;
   stss_pkg::save_kind_type hit_kind_ff, hit_kind_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   stss_pkg::save_kind_type rsp_kind_ff, rsp_kind_in;

   stss_pkg::view_type   view;
   stss_pkg::save_kind_type kind_now;
   logic                 advance;
   logic                 req_xfer;
   logic                 far_enough;

   always_comb begin
      for (int i = 0; i < stss_pkg::WIN_DEPTH; i++) begin
         view[i] = win_ff[i];
      end
      view[stss_pkg::WIN_DEPTH] = s1_data_ff;
   end

   assign kind_now   = stss_pkg::classify(view);
   assign advance    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign far_enough = ({1'b0, hit_pos_ff} + FOLLOW) <= {1'b0, count_ff};

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      s1_last_in   = s1_last_ff;
      win_in       = win_ff;
      count_in     = count_ff;
      hit_found_in = hit_found_ff;
      hit_pos_in   = hit_pos_ff;
      hit_kind_in  = hit_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;

      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_tdata;
         s1_last_in  = req_tlast;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      if (advance) begin
         for (int i = 0; i < stss_pkg::WIN_DEPTH - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[stss_pkg::WIN_DEPTH-1] = s1_data_ff;
         if (s1_last_ff) begin
            // a hit found on the last byte can never have enough bytes after it
            rsp_valid_in = 1'b1;
            rsp_kind_in  = (hit_found_ff && far_enough) ? hit_kind_ff : stss_pkg::KIND_NONE;
            count_in     = '0;
            hit_found_in = 1'b0;
            hit_pos_in   = '0;
            hit_kind_in  = stss_pkg::KIND_NONE;
         end else begin
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            if (!hit_found_ff && (count_ff >= FIRST_TEST)
                && (kind_now != stss_pkg::KIND_NONE)) begin
               hit_found_in = 1'b1;
               hit_kind_in  = kind_now;
               hit_pos_in   = count_ff - FIRST_TEST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         hit_found_ff <= 1'b0;
         hit_pos_ff   <= '0;
         hit_kind_ff  <= stss_pkg::KIND_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         hit_found_ff <= hit_found_in;
         hit_pos_ff   <= hit_pos_in;
         hit_kind_ff  <= hit_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      s1_last_ff  <= s1_last_in;
      win_ff      <= win_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_kind_ff};

endmodule

`default_nettype wire

// ----- rtl/stss_checker.sv -----
// port-level checker for the save type scanner, bound to the top level
`default_nettype none

`include "save_type_signature_scanner_assert.svh"

module stss_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   logic rsp_stall;
   logic kind_ok;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign kind_ok   = (rsp_tdata[7:3] == 5'b00000) && (rsp_tdata[2:0] <= 3'd4);

   // a stalled result holds
   `STSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // only known save kinds leave the block
   `STSS_ASSERT_IMPLY(a_rsp_kind, clock, reset, rsp_tvalid, kind_ok)

   // input back-pressure only while a result is stuck
   `STSS_ASSERT_IMPLY(a_req_block, clock, reset, !req_tready, rsp_stall)

   // no result right after reset
   `STSS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind save_type_signature_scanner stss_checker u_stss_checker (.*);

`default_nettype wire
